>>> rtl/assert_macros.svh
// Assertion helper macros for the checker file.
// No dependencies; pulled in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Signal must keep its value in the cycle after cond.
`define ASSERT_HOLD(lbl, ck, rs, cond, sig, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond) |=> $stable(sig)) else $error(msg);

`endif

>>> rtl/wrs_pkg.sv
// Shared constants for the weighted random selector.
// No dependencies; imported by the top level, the checker and the testbench.
`timescale 1ns / 1ps

package wrs_pkg;

  // Default configuration
  localparam int ENTRIES_DEF     = 32;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int RANDOM_BITS_DEF = 16;

  // Fixed field widths of the ports
  localparam int INDEX_W  = 5;
  localparam int WEIGHT_W = 16;
  localparam int RANDOM_W = 16;

  // action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_DRAW  = 1'b1;

  // result_kind codes
  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_SEL = 1'b1;

endpackage

>>> rtl/wrs_cell.sv
// One cell of the weight chain: holds a weight, forms the running sum
// and the first-hit search stage. No package dependency.
`timescale 1ns / 1ps

module wrs_cell #(
  parameter int WEIGHT_BITS = 16,
  parameter int SUM_BITS    = 21,
  parameter int RANDOM_BITS = 16,
  parameter int INDEX_BITS  = 5,
  parameter int CELL_INDEX  = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            we,
  input  logic [WEIGHT_BITS-1:0]          wdata,
  input  logic [SUM_BITS-1:0]             cum_in,
  input  logic                            hit_in,
  input  logic [INDEX_BITS-1:0]           idx_in,
  input  logic [SUM_BITS+RANDOM_BITS-1:0] thr,
  output logic [SUM_BITS-1:0]             cum_out,
  output logic                            hit_out,
  output logic [INDEX_BITS-1:0]           idx_out
);

  localparam logic [INDEX_BITS-1:0] MY_IDX = INDEX_BITS'(CELL_INDEX);

  logic [WEIGHT_BITS-1:0] weight;
  logic                   self_hit;

  // cum_out holds the cumulative weight of entries 0..CELL_INDEX once settled
  assign self_hit = {cum_out, {RANDOM_BITS{1'b0}}} >= thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight  <= '0;
      cum_out <= '0;
      hit_out <= 1'b0;
    end else begin
      if (we) begin
        weight <= wdata;
      end
      cum_out <= cum_in + {{(SUM_BITS-WEIGHT_BITS){1'b0}}, weight};
      hit_out <= hit_in | self_hit;
    end
  end

  // lowest hitting index wins
  always_ff @(posedge clk) begin
    idx_out <= hit_in ? idx_in : MY_IDX;
  end

endmodule

>>> rtl/wrs_mult.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// No package dependency.
`timescale 1ns / 1ps

module wrs_mult #(
  parameter int MCAND_BITS  = 21,
  parameter int MPLIER_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [MCAND_BITS-1:0]             mcand,
  input  logic [MPLIER_BITS-1:0]            mplier,
  output logic                              done,
  output logic [MCAND_BITS+MPLIER_BITS-1:0] product
);

  localparam int CNT_W = $clog2(MPLIER_BITS + 1);

  logic [MCAND_BITS:0]    hi;
  logic [MPLIER_BITS-1:0] lo;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic [MCAND_BITS:0]    sum;

  assign sum     = hi + (lo[0] ? {1'b0, mcand} : '0);
  assign product = {hi[MCAND_BITS-1:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MPLIER_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi <= '0;
      lo <= mplier;
    end else if (busy) begin
      hi <= {1'b0, sum[MCAND_BITS:1]};
      lo <= {sum[0], lo[MPLIER_BITS-1:1]};
    end
  end

endmodule

>>> rtl/weighted_random_selector_top.sv
// Weighted random selector, top level: control, chain of weight cells
// and the threshold multiplier. Depends on wrs_pkg, wrs_cell, wrs_mult.
`timescale 1ns / 1ps

//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------------
//  item    | item_valid/item_stall  | action, entry_index, weight_value, random_fraction
//  result  | result_valid/result_stall | result_kind, selected_index, zero_total
//
//  A write is accepted, then the result register is loaded from ST_DONE.
//  A draw first waits in ST_SUM until the running sum of any earlier write has
//  rippled down the cell chain, then the serial multiplier runs in ST_MUL, then
//  the search ripples in ST_SCAN; when every weight is zero it goes from ST_SUM
//  straight to ST_DONE.
//  Synchronous active-high rst clears all weights to zero.
//  One transaction is in flight at a time; a finished result waits in the
//  result register while the next transaction is taken. A stalled result
//  holds the following one in ST_DONE, and with it the input.

module weighted_random_selector_top
  import wrs_pkg::*;
#(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
  parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                action,
  input  logic [INDEX_W-1:0]  entry_index,
  input  logic [WEIGHT_W-1:0] weight_value,
  input  logic [RANDOM_W-1:0] random_fraction,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                result_kind,
  output logic [INDEX_W-1:0]  selected_index,
  output logic                zero_total
);

  localparam int IW  = $clog2(ENTRIES);           // cell index width
  localparam int SW  = WEIGHT_BITS + IW;          // running-sum width, no overflow
  localparam int TW  = SW + RANDOM_BITS;          // threshold / scaled sum width
  localparam int CW  = $clog2(ENTRIES + 1);       // ripple counters

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;

  logic                   item_accept;
  logic                   wr_strobe;
  logic                   out_free;
  logic [WEIGHT_BITS-1:0] wdata;
  logic [RANDOM_BITS-1:0] rnd_in;
  logic [RANDOM_BITS-1:0] rnd;
  logic [CW-1:0]          settle_cnt;
  logic [CW-1:0]          scan_cnt;
  logic [TW-1:0]          thr;
  logic [SW-1:0]          total;
  logic                   mul_start;
  logic                   mul_done;
  logic [TW-1:0]          mul_product;
  logic [IW-1:0]          sel_full;
  logic [INDEX_W-1:0]     sel_port;
  logic                   pend_kind;
  logic [INDEX_W-1:0]     pend_idx;
  logic                   pend_zero;

  // chain links; element k feeds cell k
  logic [SW-1:0]          cum_link [ENTRIES+1];
  logic                   hit_link [ENTRIES+1];
  logic [IW-1:0]          idx_link [ENTRIES+1];

  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign wr_strobe   = item_accept && (action == ACT_WRITE);
  assign out_free    = !result_valid || !result_stall;

  // field width adaptation: weights and fractions are taken modulo 2^bits
  generate
    if (WEIGHT_BITS <= WEIGHT_W) begin : g_w_trunc
      assign wdata = weight_value[WEIGHT_BITS-1:0];
    end else begin : g_w_ext
      assign wdata = {{(WEIGHT_BITS-WEIGHT_W){1'b0}}, weight_value};
    end
    if (RANDOM_BITS <= RANDOM_W) begin : g_r_trunc
      assign rnd_in = random_fraction[RANDOM_BITS-1:0];
    end else begin : g_r_ext
      assign rnd_in = {{(RANDOM_BITS-RANDOM_W){1'b0}}, random_fraction};
    end
    if (IW >= INDEX_W) begin : g_i_trunc
      assign sel_port = sel_full[INDEX_W-1:0];
    end else begin : g_i_ext
      assign sel_port = {{(INDEX_W-IW){1'b0}}, sel_full};
    end
  endgenerate

  // head of the chain
  assign cum_link[0] = '0;
  assign hit_link[0] = 1'b0;
  assign idx_link[0] = '0;

  // Cell chain: cum ripples down one cell per cycle; so does the first-hit
  // search against the broadcast threshold. An out-of-range index matches no cell.
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    logic we;
    assign we = wr_strobe && ({{(32-INDEX_W){1'b0}}, entry_index} == 32'(k));

    wrs_cell #(
      .WEIGHT_BITS (WEIGHT_BITS),
      .SUM_BITS    (SW),
      .RANDOM_BITS (RANDOM_BITS),
      .INDEX_BITS  (IW),
      .CELL_INDEX  (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .we      (we),
      .wdata   (wdata),
      .cum_in  (cum_link[k]),
      .hit_in  (hit_link[k]),
      .idx_in  (idx_link[k]),
      .thr     (thr),
      .cum_out (cum_link[k+1]),
      .hit_out (hit_link[k+1]),
      .idx_out (idx_link[k+1])
    );
  end

  assign total = cum_link[ENTRIES];

  // no hit cannot happen with exact arithmetic; last entry as fallback
  assign sel_full = hit_link[ENTRIES] ? idx_link[ENTRIES] : IW'(ENTRIES - 1);

  // threshold = r * total, computed once the sum has settled
  assign mul_start = (state == ST_SUM) && (settle_cnt == '0) && (total != '0);

  wrs_mult #(
    .MCAND_BITS  (SW),
    .MPLIER_BITS (RANDOM_BITS)
  ) u_mult (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (total),
    .mplier  (rnd),
    .done    (mul_done),
    .product (mul_product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      settle_cnt   <= '0;
      scan_cnt     <= '0;
    end else begin
      // ST_DONE reloads the result register itself when it is taken
      if (result_valid && !result_stall && (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end

      // after a write, draws wait until settle_cnt is back to zero and the chain total is valid again
      if (wr_strobe) begin
        settle_cnt <= CW'(ENTRIES);
      end else if (settle_cnt != '0) begin
        settle_cnt <= settle_cnt - 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (item_accept) begin
            if (action == ACT_WRITE) begin
              pend_kind <= KIND_ACK;
              pend_idx  <= '0;
              pend_zero <= 1'b0;
              state     <= ST_DONE;
            end else begin
              rnd   <= rnd_in;
              state <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          if (settle_cnt == '0) begin
            if (total == '0) begin
              pend_kind <= KIND_SEL;
              pend_idx  <= '0;
              pend_zero <= 1'b1;
              state     <= ST_DONE;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            thr      <= mul_product;
            scan_cnt <= CW'(ENTRIES);
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_cnt == '0) begin
            pend_kind <= KIND_SEL;
            pend_idx  <= sel_port;
            pend_zero <= 1'b0;
            state     <= ST_DONE;
          end else begin
            scan_cnt <= scan_cnt - 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            result_valid   <= 1'b1;
            result_kind    <= pend_kind;
            selected_index <= pend_idx;
            zero_total     <= pend_zero;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/wrs_checker.sv
// Port-level checker for the weighted random selector, bound to the top.
// Depends on wrs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wrs_checker
  import wrs_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input logic                action,
  input logic [INDEX_W-1:0]  entry_index,
  input logic [WEIGHT_W-1:0] weight_value,
  input logic [RANDOM_W-1:0] random_fraction,
  input logic                result_valid,
  input logic                result_stall,
  input logic                result_kind,
  input logic [INDEX_W-1:0]  selected_index,
  input logic                zero_total
);

  `ASSERT_HOLD(a_result_hold, clk, rst, result_valid && result_stall, {result_valid, result_kind, selected_index, zero_total}, "stalled result changed")
  `ASSERT_ALWAYS(a_ack_fields, clk, rst, (result_valid && result_kind == KIND_ACK) |-> (selected_index == '0 && !zero_total), "write ack with nonzero fields")
  `ASSERT_ALWAYS(a_zero_draw, clk, rst, (result_valid && zero_total) |-> (result_kind == KIND_SEL && selected_index == '0), "zero total draw not index 0")
  `ASSERT_ALWAYS(a_busy_after_accept, clk, rst, (item_valid && !item_stall) |=> item_stall, "second transaction taken while busy")

endmodule

bind weighted_random_selector_top wrs_checker u_wrs_checker (.*);

>>> dv/tb_weighted_random_selector_top.sv
// Self-checking testbench for weighted_random_selector_top: weight writes and
// roulette-wheel draws, checked against an in-bench cumulative-weight predictor.
// Depends on wrs_pkg and the RTL of the block; nothing else.
`timescale 1ns / 1ps

module tb_weighted_random_selector_top;
  import wrs_pkg::*;

  // The limit leaves a wide margin over the slowest correct run of roughly 725
  // transactions plus the long hold-off.
  localparam int unsigned CYCLE_LIMIT  = 800000;
  localparam int unsigned DRAIN_CYCLES = 120;   // > worst draw latency
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned MAX_WAIT     = 18;
  localparam int unsigned HOLD_AFTER   = 200;   // accepted items before the hold-off
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct packed {
    logic                action;
    logic [INDEX_W-1:0]  entry_index;
    logic [WEIGHT_W-1:0] weight_value;
    logic [RANDOM_W-1:0] random_fraction;
  } request_t;

  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] index;
    logic               zero;
  } selection_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block I/O. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic                item_valid      = 1'b0;
  logic                item_stall;
  logic                action          = ACT_WRITE;
  logic [INDEX_W-1:0]  entry_index     = '0;
  logic [WEIGHT_W-1:0] weight_value    = '0;
  logic [RANDOM_W-1:0] random_fraction = '0;
  logic                result_valid;
  logic                result_stall    = 1'b0;
  logic                result_kind;
  logic [INDEX_W-1:0]  selected_index;
  logic                zero_total;

  weighted_random_selector_top i_dut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .action          (action),
    .entry_index     (entry_index),
    .weight_value    (weight_value),
    .random_fraction (random_fraction),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result_kind     (result_kind),
    .selected_index  (selected_index),
    .zero_total      (zero_total)
  );

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  request_t            queued_requests[$];     // stimulus not yet offered
  selection_t          predicted_outcomes[$];  // oldest first
  logic [WEIGHT_W-1:0] weight_shadow[ENTRIES_DEF];
  logic [31:0]         live_entries = '0;      // generator view: nonzero weights
  logic                item_accepted = 1'b0;   // item handshake at last rising edge
  logic                result_taken  = 1'b0;   // result handshake at last rising edge
  int unsigned         items_taken   = 0;
  int unsigned         fail_count    = 0;
  int unsigned         cycle_count   = 0;
  int unsigned         hold_off_left = 0;
  bit                  hold_off_done = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor: lowest index whose cumulative weight satisfies
  // cum * 2^RANDOM_BITS >= r * total. Exact integers, no division.
  // Sums stay below 2^21 and r * total below 2^37, so 64 bits is plenty.
  // ---------------------------------------------------------------------------
  function automatic selection_t predict_selection(input logic [RANDOM_W-1:0] fraction);
    selection_t  res;
    logic [63:0] total;
    logic [63:0] running;
    logic [63:0] threshold;
    bit          found;
    int          i;
    res.kind  = KIND_SEL;
    res.index = INDEX_W'(ENTRIES_DEF - 1);  // no qualifying index: last entry
    res.zero  = 1'b0;
    total     = '0;
    for (i = 0; i < ENTRIES_DEF; i++) total += 64'(weight_shadow[i]);
    if (total == 64'd0) begin
      res.index = '0;
      res.zero  = 1'b1;
      return res;
    end
    threshold = 64'(fraction) * total;
    running   = '0;
    found     = 1'b0;
    for (i = 0; i < ENTRIES_DEF; i++) begin
      running += 64'(weight_shadow[i]);
      // first hit wins, so equal cumulative sums resolve to the lowest index
      if (!found && ((running << RANDOM_BITS_DEF) >= threshold)) begin
        res.index = INDEX_W'(i);
        found     = 1'b1;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Fields a transaction ignores carry random filler.
  // ---------------------------------------------------------------------------
  task automatic push_write(input int idx, input logic [WEIGHT_W-1:0] w);
    request_t req;
    req.action          = ACT_WRITE;
    req.entry_index     = INDEX_W'(idx);
    req.weight_value    = w;
    req.random_fraction = RANDOM_W'($urandom);
    queued_requests.push_back(req);
    live_entries[idx] = (w != '0);
  endtask

  task automatic push_draw(input logic [RANDOM_W-1:0] r);
    request_t req;
    req.action          = ACT_DRAW;
    req.entry_index     = INDEX_W'($urandom);
    req.weight_value    = WEIGHT_W'($urandom);
    req.random_fraction = r;
    queued_requests.push_back(req);
  endtask

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return WEIGHT_W'($urandom_range(1, 15));
      default: return WEIGHT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [RANDOM_W-1:0] pick_fraction();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return RANDOM_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued transactions at the falling edge, after a random wait
  // before each, with occasional stretches of back-to-back items.
  // A transaction stays on the pins until the rising edge that takes it.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : item_driver
    static int unsigned send_wait = 0;
    static int unsigned send_calm = 0;
    request_t req;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_valid && !item_accepted) begin
      // stalled: hold payload
    end else if (send_wait > 0) begin
      item_valid <= 1'b0;
      send_wait--;
    end else if (queued_requests.size() > 0) begin
      req = queued_requests.pop_front();
      action          <= req.action;
      entry_index     <= req.entry_index;
      weight_value    <= req.weight_value;
      random_fraction <= req.random_fraction;
      item_valid      <= 1'b1;
      // gap before the following transaction
      if (send_calm > 0) begin
        send_calm--;
        send_wait = 0;
      end else begin
        send_wait = $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 24) == 0) send_calm = $urandom_range(10, 40);
      end
    end else begin
      item_valid <= 1'b0;
    end
  end

  // Item side of the monitor: every accepted transaction updates the weight
  // shadow or runs the predictor, in acceptance order.
  always @(posedge clk) begin : item_monitor
    int i;
    item_accepted <= !rst && item_valid && !item_stall;
    if (rst) begin
      for (i = 0; i < ENTRIES_DEF; i++) weight_shadow[i] = '0;
    end else if (item_valid && !item_stall) begin
      items_taken++;
      if (action == ACT_WRITE) begin
        if (entry_index < ENTRIES_DEF) weight_shadow[entry_index] = weight_value;
        predicted_outcomes.push_back('{kind: KIND_ACK, index: '0, zero: 1'b0});
      end else begin
        predicted_outcomes.push_back(predict_selection(random_fraction));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long hold-off: once enough traffic has gone in, the receiver refuses results
  // while hold_off_left counts down, so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : hold_off_timer
    if (!hold_off_done && items_taken >= HOLD_AFTER) begin
      hold_off_left <= HOLD_CYCLES;
      hold_off_done <= 1'b1;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
    end
  end

  // Receiver: a random stall per result, counted while a result is waiting,
  // plus calm stretches with no stall at all.
  always @(negedge clk) begin : result_receiver
    static int unsigned recv_wait = 0;
    static int unsigned recv_calm = 0;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_taken) begin
        if (recv_calm > 0) begin
          recv_calm--;
          recv_wait = 0;
        end else begin
          recv_wait = $urandom_range(0, MAX_WAIT);
          if ($urandom_range(0, 24) == 0) recv_calm = $urandom_range(10, 40);
        end
      end
      result_stall <= (recv_wait > 0) || (hold_off_left > 0);
      if (result_valid && recv_wait > 0) recv_wait--;
    end
  end

  // Result side of the monitor: compare each accepted result with the oldest
  // prediction, field by field.
  always @(posedge clk) begin : result_monitor
    selection_t exp;
    result_taken <= !rst && result_valid && !result_stall;
    if (!rst && result_valid && !result_stall) begin
      if (predicted_outcomes.size() == 0) begin
        $error("result with no transaction outstanding: kind %0d index %0d zero %0d",
               result_kind, selected_index, zero_total);
        fail_count++;
      end else begin
        exp = predicted_outcomes.pop_front();
        if (result_kind !== exp.kind) begin
          $error("result_kind: expected %0d, got %0d", exp.kind, result_kind);
          fail_count++;
        end
        if (selected_index !== exp.index) begin
          $error("selected_index: expected %0d, got %0d", exp.index, selected_index);
          fail_count++;
        end
        if (zero_total !== exp.zero) begin
          $error("zero_total: expected %0d, got %0d", exp.zero, zero_total);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_weighted_random_selector_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    int n;
    int k;
    // Directed part
    push_draw('0);                 // table empty after reset: zero total
    push_draw('1);
    push_write(31, '1);
    push_draw('0);                 // zero fraction picks index 0 despite weight 0
    push_draw('1);                 // lands on the only live entry
    push_write(0, 16'd1);
    push_draw('0);
    push_draw(16'd1);              // cum0 * 2^16 == r * total exactly
    push_draw(16'd2);
    push_write(15, '1);
    push_draw(16'h8000);
    push_draw(16'h7FFF);
    push_draw('1);
    push_write(31, '0);            // entries 16..31 now share entry 15's cum sum
    push_draw('1);
    push_write(0, '0);
    push_write(15, '0);
    push_draw(16'h1234);           // all weights zero again
    push_write(1, 16'hAAAA);
    push_write(30, 16'h5555);
    push_draw(16'hAAAA);
    push_draw(16'hAAAB);
    push_draw(16'h5555);

    // Random part: episodes of writes followed by draws over the result
    while (queued_requests.size() < RANDOM_ITEMS + 23) begin
      case ($urandom_range(0, 9))
        0: begin
          // wipe every live entry, then draw against an empty table
          for (i = 0; i < ENTRIES_DEF; i++)
            if (live_entries[i]) push_write(i, '0);
          push_draw(pick_fraction());
        end
        1, 2: begin
          n = $urandom_range(8, 32);
          for (k = 0; k < n; k++) push_write($urandom_range(0, ENTRIES_DEF - 1), pick_weight());
          n = $urandom_range(2, 4);
          for (k = 0; k < n; k++) push_draw(pick_fraction());
        end
        default: begin
          n = $urandom_range(1, 3);
          for (k = 0; k < n; k++) push_write($urandom_range(0, ENTRIES_DEF - 1), pick_weight());
          n = $urandom_range(3, 8);
          for (k = 0; k < n; k++) push_draw(pick_fraction());
        end
      endcase
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for every transaction to be taken and answered
    while (queued_requests.size() > 0 || item_valid || predicted_outcomes.size() > 0)
      @(posedge clk);
    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && predicted_outcomes.size() == 0) begin
      $display("tb_weighted_random_selector_top: PASS");
    end else begin
      $display("tb_weighted_random_selector_top: FAIL");
    end
    $finish;
  end

endmodule
